// ----- src/sbe_pkg.sv -----
// Package for the S/PDIF biphase frame encoder: word types, header
// constants and the biphase mark code function.
// No dependencies.
package sbe_pkg;

  // One stereo frame as it enters the block.
  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_word_t;

  // One coded word as it leaves the block.
  typedef struct packed {
    logic [31:0] coded_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Word positions within a frame.
  localparam logic [1:0] IdxLeftData  = 2'd0;
  localparam logic [1:0] IdxLeftHdr   = 2'd1;
  localparam logic [1:0] IdxRightData = 2'd2;
  localparam logic [1:0] IdxRightHdr  = 2'd3;

  // Header word fields.
  localparam logic [7:0]  HdrVucp   = 8'hCC;
  localparam logic [7:0]  PreBlock  = 8'hE8;
  localparam logic [7:0]  PreLeft   = 8'hE2;
  localparam logic [7:0]  PreRight  = 8'hE4;
  localparam logic [15:0] AuxOne    = 16'hCCCC;
  localparam logic [15:0] AuxZero   = 16'hB333;

  // Biphase mark code of one byte. Byte bit 0 lands in code bits 15:14.
  // Each cell opens with a level change and a one adds a mid-cell change.
  // The result is flipped so that code bit 0 is low.
  function automatic logic [15:0] bmc_byte(input logic [7:0] data);
    logic [15:0] code;
    logic        lvl;
    code = '0;
    lvl  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      lvl = ~lvl;
      code[15 - 2 * i] = lvl;
      lvl = lvl ^ data[i];
      code[14 - 2 * i] = lvl;
    end
    if (code[0]) begin
      code = ~code;
    end
    return code;
  endfunction

endpackage

// ----- src/sbe_chan_enc.sv -----
// Channel encoder: turns one 16-bit sample and its preamble into a data
// word and a header word. Depends on sbe_pkg.
module sbe_chan_enc (
  input  logic [15:0] sample_i,
  input  logic [7:0]  preamble_i,
  output logic [31:0] data_word_o,
  output logic [31:0] hdr_word_o
);
  import sbe_pkg::*;

  logic [15:0] hi_code;
  logic [15:0] lo_raw;
  logic [15:0] lo_code;
  logic [15:0] aux;

  // Code both bytes; the low code follows the end level of the high code.
  always_comb begin
    hi_code = bmc_byte(sample_i[15:8]);
    lo_raw  = bmc_byte(sample_i[7:0]);
    lo_code = hi_code[15] ? lo_raw : ~lo_raw;
    aux     = lo_code[15] ? AuxOne : AuxZero;
  end

  assign data_word_o = {lo_code, hi_code};
  assign hdr_word_o  = {HdrVucp, preamble_i, aux};

endmodule

// ----- src/sbe_word_ser.sv -----
// Frame buffer and serializer: holds the four words of one frame and
// sends them one per cycle while out_stall_i is low. Depends on sbe_pkg.
module sbe_word_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [3:0][31:0]  words_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbe_pkg::out_word_t out_word_o
);
  import sbe_pkg::*;

  logic [3:0][31:0] words_q;
  logic [1:0]       idx_q, idx_d;
  logic             valid_q, valid_d;
  logic             take;
  logic             last;

  // A word leaves when valid and not stalled; the frame ends on the last one.
  assign take    = valid_q && !out_stall_i;
  assign last    = (idx_q == IdxRightHdr);
  assign ready_o = !valid_q || (take && last);

  // Word position and buffer occupancy.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      idx_d   = IdxLeftData;
      valid_d = 1'b1;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
      if (last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IdxLeftData;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Frame words need no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end
  end

  assign out_valid_o           = valid_q;
  assign out_word_o.coded_word = words_q[idx_q];
  assign out_word_o.word_index = idx_q;
  assign out_word_o.last_word  = last;

endmodule

// ----- src/spdif_biphase_frame_encoder.sv -----
// S/PDIF biphase frame encoder top level: input register, block counter,
// channel encoders and output serializer. Depends on sbe_pkg,
// sbe_chan_enc and sbe_word_ser.
//
// Each accepted stereo frame yields four words, in order left data, left
// header, right data, right header, one per cycle on the output while
// out_stall_i is low. A frame is registered, coded combinationally and
// parked in a four-word buffer; the next frame is taken into the input
// register while that buffer drains, so the block accepts a new frame
// before the last one has left. The first word of a frame comes out of
// the frame buffer, which is loaded from the input register. The left
// header carries the block-start preamble on every BLOCK_FRAMES-th frame
// after reset, the first such frame being frame number BLOCK_FRAMES.
module spdif_biphase_frame_encoder #(
  parameter int BLOCK_FRAMES = 192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbe_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbe_pkg::out_word_t out_word_o
);
  import sbe_pkg::*;

  localparam int CntW = (BLOCK_FRAMES > 2) ? $clog2(BLOCK_FRAMES) : 1;
  localparam logic [CntW:0] BlockLim = (CntW + 1)'(BLOCK_FRAMES);

  in_word_t         in_q;
  logic             in_valid_q, in_valid_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW:0]    cnt_inc;
  logic             block_start;
  logic [7:0]       left_pre;
  logic             ser_ready;
  logic             load;
  logic             in_take;
  logic [3:0][31:0] frame_words;

  // Handshake between the input register and the frame buffer.
  assign load       = in_valid_q && ser_ready;
  assign in_stall_o = in_valid_q && !ser_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  // Block counter advances once per frame moved into the buffer.
  always_comb begin
    cnt_inc     = {1'b0, cnt_q} + (CntW + 1)'(1);
    block_start = (cnt_inc >= BlockLim);
    cnt_d       = cnt_q;
    if (load) begin
      cnt_d = block_start ? '0 : cnt_inc[CntW-1:0];
    end
    left_pre = block_start ? PreBlock : PreLeft;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  // Code both channels of the registered frame.
  sbe_chan_enc u_enc_left (
    .sample_i    (in_q.left_sample),
    .preamble_i  (left_pre),
    .data_word_o (frame_words[IdxLeftData]),
    .hdr_word_o  (frame_words[IdxLeftHdr])
  );

  sbe_chan_enc u_enc_right (
    .sample_i    (in_q.right_sample),
    .preamble_i  (PreRight),
    .data_word_o (frame_words[IdxRightData]),
    .hdr_word_o  (frame_words[IdxRightHdr])
  );

  sbe_word_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .words_i     (frame_words),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // The block counter never reaches the block length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < BlockLim)
    else $error("block counter out of range");

  // Within a frame, a taken word is followed by the next word position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_word_o.last_word)
      |=> (out_valid_o && out_word_o.word_index == $past(out_word_o.word_index) + 2'd1))
    else $error("word sequence broken");

  // Header words carry the fixed status byte on top.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.word_index[0]) |-> out_word_o.coded_word[31:24] == HdrVucp)
    else $error("header word malformed");

endmodule

// ----- bench/spdif_biphase_frame_encoder_chk.sv -----
`timescale 1ns / 1ps
// Checker for the S/PDIF biphase frame encoder: predicts the four coded words
// of each accepted frame and compares them with the output channel.
// Depends on sbe_pkg for the word types and header constants.
module spdif_biphase_frame_encoder_chk #(
  parameter int BLOCK_FRAMES = 192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sbe_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sbe_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 frames_o,
  output int                 words_o,
  output int                 block_starts_o
);

  import sbe_pkg::*;

  // Words still owed by the block, oldest first.
  out_word_t expected_words[$];
  // Frames since the last block start, as the block should count them.
  int        frames_in_block;
  out_word_t want;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    frames_o        = 0;
    words_o         = 0;
    block_starts_o  = 0;
    frames_in_block = 0;
  end

  // Biphase mark code of one byte, byte bit 0 in the top cell. Every cell
  // starts by toggling the line and a one toggles it again mid-cell; the
  // whole code is flipped at the end so that the last half-cell is low.
  function automatic logic [15:0] biphase_code(input logic [7:0] b);
    logic [15:0] sym;
    logic        line;
    line = 1'b1;
    for (int k = 0; k < 8; k++) begin
      line = ~line;
      sym[15 - 2 * k] = line;
      if (b[k]) line = ~line;
      sym[14 - 2 * k] = line;
    end
    return sym[0] ? ~sym : sym;
  endfunction

  // Queue the data word and the header word of one channel.
  function automatic void queue_channel(input logic [15:0] sample, input logic [7:0] pre,
                                        input logic [1:0] data_idx);
    logic [15:0] hi_code;
    logic [15:0] lo_code;
    out_word_t   w;
    hi_code = biphase_code(sample[15:8]);
    lo_code = biphase_code(sample[7:0]);
    // The low code follows on from the level the high code ends the word on.
    if (!hi_code[15]) lo_code = ~lo_code;
    w.coded_word = {lo_code, hi_code};
    w.word_index = data_idx;
    w.last_word  = 1'b0;
    expected_words.push_back(w);
    w.coded_word = {HdrVucp, pre, (lo_code[15] ? AuxOne : AuxZero)};
    w.word_index = data_idx + 2'd1;
    w.last_word  = (data_idx == IdxRightData);
    expected_words.push_back(w);
  endfunction

  // Advance the block counter and queue the four words of a frame.
  function automatic void encode_frame(input in_word_t f);
    logic [7:0] left_pre;
    left_pre = PreLeft;
    frames_in_block++;
    if (frames_in_block >= BLOCK_FRAMES) begin
      left_pre        = PreBlock;
      frames_in_block = 0;
      block_starts_o++;
    end
    queue_channel(f.left_sample, left_pre, IdxLeftData);
    queue_channel(f.right_sample, PreRight, IdxRightData);
    frames_o++;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    fail_count_o++;
    $display("%0t: word %0d %s mismatch: expected %h, actual %h",
             $time, words_o, field, exp_v, act_v);
  endfunction

  // Compare each delivered word, then record each accepted frame.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected word", 32'h0, out_word_i.coded_word);
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.coded_word !== want.coded_word)
            note_mismatch("coded_word", want.coded_word, out_word_i.coded_word);
          if (out_word_i.word_index !== want.word_index)
            note_mismatch("word_index", want.word_index, out_word_i.word_index);
          if (out_word_i.last_word !== want.last_word)
            note_mismatch("last_word", want.last_word, out_word_i.last_word);
        end
        words_o++;
      end
      if (in_valid_i && !in_stall_i) encode_frame(in_word_i);
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- bench/spdif_biphase_frame_encoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the S/PDIF biphase frame encoder: clock, reset, frame
// stimulus with random idling on both sides, watchdog and verdict.
// Depends on sbe_pkg, the encoder RTL and spdif_biphase_frame_encoder_chk.
module spdif_biphase_frame_encoder_tb;

  import sbe_pkg::*;

  localparam int BLOCK_FRAMES = 192;
  localparam int RANDOM_FRAMES = 410;
  localparam int CALM_FRAMES = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT = 4000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int fail_count;
  int pending;
  int frames;
  int words;
  int block_starts;

  // Idling controls: chance in eighths of a new burst, and a quiet flag.
  int gap_chance;
  int stall_chance;
  bit calm;
  int stall_left;
  int idle_cycles;

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    out_stall   = 1'b0;
    gap_chance  = 2;
    stall_chance = 2;
    calm        = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
  end

  always #2 clk_i = ~clk_i;

  spdif_biphase_frame_encoder #(
    .BLOCK_FRAMES(BLOCK_FRAMES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  spdif_biphase_frame_encoder_chk #(
    .BLOCK_FRAMES(BLOCK_FRAMES)
  ) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .frames_o      (frames),
    .words_o       (words),
    .block_starts_o(block_starts)
  );

  // Output side stall in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) < stall_chance) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("spdif_biphase_frame_encoder_tb: FAIL");
        $finish;
      end
    end
  end

  // Offer one frame, possibly after an idle burst, and wait for its accept.
  task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) < gap_chance) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid              <= 1'b1;
    in_word.left_sample   <= left;
    in_word.right_sample  <= right;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Pick a sample: mostly uniform, sometimes one of the range extremes.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: range extremes, alternating patterns, single bits
    // and byte boundaries, so both aux values and both code polarities occur.
    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555);
    send_frame(16'h00FF, 16'hFF00);
    send_frame(16'hFF00, 16'h00FF);
    send_frame(16'h0001, 16'h0100);
    send_frame(16'h0080, 16'h8080);
    send_frame(16'h0101, 16'hFEFE);
    send_frame(16'h0F0F, 16'hF0F0);
    send_frame(16'h3333, 16'hCCCC);
    send_frame(16'h1234, 16'hEDCB);
    send_frame(16'h0002, 16'h4000);
    send_frame(16'hFFFE, 16'h7F7F);

    // Random frames; the idling mix changes every 40 frames and the tail
    // runs with no idling at all. The run crosses two block starts.
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 40 == 0) begin
        gap_chance   = $urandom_range(0, 5);
        stall_chance = $urandom_range(0, 4);
      end
      if (n == RANDOM_FRAMES - CALM_FRAMES) calm = 1'b1;
      send_frame(pick_sample(), pick_sample());
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    // Drain: wait until every word is in, then a few more cycles.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d frames and %0d coded words, with %0d block-start headers.",
             frames, words, block_starts);
    if (fail_count == 0 && pending == 0) begin
      $display("spdif_biphase_frame_encoder_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d words never delivered", fail_count, pending);
      $display("spdif_biphase_frame_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
